// ===== rtl/core/cesd_pkg.sv =====
// Package for the C escape sequence decoder.
// Holds the scan mode type, character constants, queue sizing and decode helpers.
// No dependencies.
`timescale 1ns / 1ps

package cesd_pkg;

  typedef enum logic [1:0] {
    MODE_TEXT = 2'd0,
    MODE_BSL  = 2'd1,
    MODE_HEX  = 2'd2,
    MODE_OCT  = 2'd3
  } mode_t;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] HEX_TEN  = 8'd10;

  localparam int MAX_RESULTS = 3;
  localparam int QUEUE_DEPTH = 8;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } result_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] value;
  } lookup_t;

  function automatic lookup_t simple_escape(input logic [7:0] b);
    lookup_t r;
    r.valid = 1'b1;
    r.value = 8'd0;
    unique case (b)
      8'h61:   r.value = 8'd7;
      8'h62:   r.value = 8'd8;
      8'h74:   r.value = 8'd9;
      8'h6E:   r.value = 8'd10;
      8'h76:   r.value = 8'd11;
      8'h66:   r.value = 8'd12;
      8'h72:   r.value = 8'd13;
      8'h27:   r.value = 8'd39;
      8'h22:   r.value = 8'd34;
      CH_BSL:  r.value = CH_BSL;
      default: r.valid = 1'b0;
    endcase
    return r;
  endfunction

  function automatic lookup_t hex_value(input logic [7:0] b);
    lookup_t r;
    r.valid = 1'b1;
    r.value = 8'd0;
    if (b >= CH_ZERO && b <= CH_NINE) begin
      r.value = b - CH_ZERO;
    end else if (b >= CH_LA && b <= CH_LF) begin
      r.value = b - CH_LA + HEX_TEN;
    end else if (b >= CH_UA && b <= CH_UF) begin
      r.value = b - CH_UA + HEX_TEN;
    end else begin
      r.valid = 1'b0;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/c_escape_sequence_decoder.sv =====
// Top level of the C escape sequence decoder.
// Holds the escape decode logic and the result queue; depends on cesd_pkg.
`timescale 1ns / 1ps

// Usage:
// The input channel (in_valid, in_ready, in_byte, in_last) takes one raw byte
// of a string literal body per word. The result channel (out_valid, out_ready,
// out_byte, out_string_end) gives the decoded bytes, and the last word of each
// string carries out_string_end high with out_byte zero.
// Each accepted byte is decoded in the cycle it is accepted and its zero to
// three result words are written into an eight-entry result queue, so they are
// held in the queue from the cycle after acceptance.
// One input word is taken every cycle while the queue has room for three more
// results; the queue drains one word per cycle, so sustained throughput is one
// byte per cycle as long as the average result count stays at or below one.
// When the receiver stalls, the queue fills and in_ready drops until space
// returns; no word is lost or repeated.
// Reset clears the queue and returns the decoder to plain text mode.
module c_escape_sequence_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_string_end
);

  import cesd_pkg::*;

  mode_t                   mode_r, mode_nxt;
  logic [7:0]              accum_r, accum_nxt;
  result_t                 res [MAX_RESULTS];
  logic [1:0]              res_n;
  result_t                 queue_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic                    push, pop;

  assign in_ready  = (count_r <= CNT_W'(QUEUE_DEPTH - MAX_RESULTS));
  assign push      = in_valid && in_ready;
  assign out_valid = (count_r != '0);
  assign pop       = out_valid && out_ready;
  assign out_byte       = queue_r[rd_ptr_r].data;
  assign out_string_end = queue_r[rd_ptr_r].last;

  always_comb begin
    lookup_t esc;
    lookup_t hex;
    logic    as_text;
    logic    ended;
    esc       = simple_escape(in_byte);
    hex       = hex_value(in_byte);
    as_text   = 1'b0;
    ended     = 1'b0;
    res_n     = 2'd0;
    mode_nxt  = mode_r;
    accum_nxt = accum_r;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      res[i] = '0;
    end

    unique case (mode_r)
      MODE_BSL: begin
        if (esc.valid) begin
          res[res_n] = '{data: esc.value, last: 1'b0};
          res_n      = res_n + 2'd1;
          mode_nxt   = MODE_TEXT;
        end else if (in_byte == CH_X) begin
          mode_nxt  = MODE_HEX;
          accum_nxt = 8'd0;
        end else if (in_byte == CH_ZERO) begin
          mode_nxt  = MODE_OCT;
          accum_nxt = 8'd0;
        end else begin
          res[res_n] = '{data: CH_BSL, last: 1'b0};
          res_n      = res_n + 2'd1;
          mode_nxt   = MODE_TEXT;
          as_text    = 1'b1;
        end
      end
      MODE_HEX: begin
        if (hex.valid) begin
          accum_nxt = {accum_r[3:0], hex.value[3:0]};
        end else begin
          res[res_n] = '{data: accum_r, last: 1'b0};
          res_n      = res_n + 2'd1;
          mode_nxt   = MODE_TEXT;
          as_text    = 1'b1;
        end
      end
      MODE_OCT: begin
        if (in_byte >= CH_ZERO && in_byte <= CH_SEVEN) begin
          accum_nxt = {accum_r[4:0], in_byte[2:0]};
        end else begin
          res[res_n] = '{data: accum_r, last: 1'b0};
          res_n      = res_n + 2'd1;
          mode_nxt   = MODE_TEXT;
          as_text    = 1'b1;
        end
      end
      default: begin
        as_text = 1'b1;
      end
    endcase

    if (as_text) begin
      if (in_byte == CH_NUL) begin
        res[res_n] = '{data: 8'd0, last: 1'b1};
        res_n      = res_n + 2'd1;
        mode_nxt   = MODE_TEXT;
        accum_nxt  = 8'd0;
        ended      = 1'b1;
      end else if (in_byte == CH_BSL) begin
        mode_nxt = MODE_BSL;
      end else begin
        res[res_n] = '{data: in_byte, last: 1'b0};
        res_n      = res_n + 2'd1;
      end
    end

    if (!ended && in_last) begin
      if (mode_nxt == MODE_BSL) begin
        res[res_n] = '{data: CH_BSL, last: 1'b0};
        res_n      = res_n + 2'd1;
      end else if (mode_nxt == MODE_HEX || mode_nxt == MODE_OCT) begin
        res[res_n] = '{data: accum_nxt, last: 1'b0};
        res_n      = res_n + 2'd1;
      end
      res[res_n] = '{data: 8'd0, last: 1'b1};
      res_n      = res_n + 2'd1;
      mode_nxt   = MODE_TEXT;
      accum_nxt  = 8'd0;
    end
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + PTR_W'(res_n);
      count_nxt  = count_nxt + CNT_W'(res_n);
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + PTR_W'(1);
      count_nxt  = count_nxt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_TEXT;
      accum_r  <= 8'd0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
      if (push) begin
        mode_r  <= mode_nxt;
        accum_r <= accum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
        if (2'(i) < res_n) begin
          queue_r[wr_ptr_r + PTR_W'(i)] <= res[i];
        end
      end
    end
  end

endmodule

// ===== tb/sv/c_escape_sequence_decoder_tb.sv =====
// Self-checking testbench for c_escape_sequence_decoder: a directed table, then random strings.
// Each decoded word is checked against typed table words or a behavioral decoder in this file.
// Depends on cesd_pkg and the c_escape_sequence_decoder RTL.
`timescale 1ns / 1ps

module c_escape_sequence_decoder_tb;
  import cesd_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       lst;
  } char_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       lst;
    logic       typed;
    logic [1:0] n;
    result_t    w0;
    result_t    w1;
  } row_t;

  localparam result_t NO_WORD  = '0;
  localparam result_t END_WORD = '{data: CH_NUL, last: 1'b1};
  localparam int DIR_ROWS  = 26;
  localparam int RAND_CHARS = 150;
  localparam int CALM_CHARS = 40;
  localparam logic [7:0] ESC_CHARS [10] = '{"a", "b", "t", "n", "v", "f", "r", "'", "\"",
                                            CH_BSL};

  // Rows with typed words are checked against those words; the rest use the decoder below.
  localparam row_t DIR_TABLE [DIR_ROWS] = '{
    '{8'h41,    1'b0, 1'b1, 2'd1, '{8'h41, 1'b0},  NO_WORD},
    '{8'hFF,    1'b0, 1'b1, 2'd1, '{8'hFF, 1'b0},  NO_WORD},
    '{CH_BSL,   1'b0, 1'b1, 2'd0, NO_WORD,         NO_WORD},
    '{"n",      1'b0, 1'b1, 2'd1, '{8'h0A, 1'b0},  NO_WORD},
    '{CH_BSL,   1'b0, 1'b0, 2'd0, NO_WORD,         NO_WORD},
    '{"\"",     1'b0, 1'b1, 2'd1, '{8'h22, 1'b0},  NO_WORD},
    '{CH_BSL,   1'b0, 1'b0, 2'd0, NO_WORD,         NO_WORD},
    '{"q",      1'b0, 1'b1, 2'd2, '{CH_BSL, 1'b0}, '{"q", 1'b0}},
    '{CH_BSL,   1'b0, 1'b0, 2'd0, NO_WORD,         NO_WORD},
    '{CH_X,     1'b0, 1'b0, 2'd0, NO_WORD,         NO_WORD},
    '{"4",      1'b0, 1'b0, 2'd0, NO_WORD,         NO_WORD},
    '{"1",      1'b0, 1'b0, 2'd0, NO_WORD,         NO_WORD},
    '{8'h80,    1'b0, 1'b0, 2'd0, NO_WORD,         NO_WORD},
    '{CH_BSL,   1'b0, 1'b0, 2'd0, NO_WORD,         NO_WORD},
    '{CH_ZERO,  1'b0, 1'b0, 2'd0, NO_WORD,         NO_WORD},
    '{"7",      1'b0, 1'b0, 2'd0, NO_WORD,         NO_WORD},
    '{"7",      1'b0, 1'b0, 2'd0, NO_WORD,         NO_WORD},
    '{"7",      1'b0, 1'b0, 2'd0, NO_WORD,         NO_WORD},
    '{"z",      1'b1, 1'b0, 2'd0, NO_WORD,         NO_WORD},
    '{CH_BSL,   1'b0, 1'b0, 2'd0, NO_WORD,         NO_WORD},
    '{CH_NUL,   1'b0, 1'b1, 2'd2, '{CH_BSL, 1'b0}, END_WORD},
    '{CH_BSL,   1'b0, 1'b0, 2'd0, NO_WORD,         NO_WORD},
    '{CH_X,     1'b0, 1'b0, 2'd0, NO_WORD,         NO_WORD},
    '{CH_NUL,   1'b1, 1'b1, 2'd2, '{8'h00, 1'b0},  END_WORD},
    '{CH_BSL,   1'b1, 1'b1, 2'd2, '{CH_BSL, 1'b0}, END_WORD},
    '{CH_NUL,   1'b1, 1'b1, 2'd1, END_WORD,        NO_WORD}
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       out_string_end;

  mode_t      scan_state = MODE_TEXT;
  logic [7:0] escape_value = 8'h00;
  result_t    step_words[$];
  result_t    expected_words[$];
  result_t    oldest_word;
  char_t      random_chars[$];
  int         errors = 0;
  int         stall_left = 0;
  bit         calm_tail = 1'b0;

  c_escape_sequence_decoder DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_string_end (out_string_end)
  );

  always #5 clk = ~clk;

  function automatic bit simple_code(input logic [7:0] b, output logic [7:0] code);
    simple_code = 1'b1;
    code = 8'h00;
    case (b)
      "a":     code = 8'd7;
      "b":     code = 8'd8;
      "t":     code = 8'd9;
      "n":     code = 8'd10;
      "v":     code = 8'd11;
      "f":     code = 8'd12;
      "r":     code = 8'd13;
      "'":     code = 8'd39;
      "\"":    code = 8'd34;
      CH_BSL:  code = CH_BSL;
      default: simple_code = 1'b0;
    endcase
  endfunction

  function automatic bit hex_digit(input logic [7:0] b, output logic [3:0] d);
    d = 4'h0;
    if (b >= CH_ZERO && b <= CH_NINE) begin
      d = 4'(b - CH_ZERO);
    end else if (b >= CH_LA && b <= CH_LF) begin
      d = 4'(b - CH_LA + HEX_TEN);
    end else if (b >= CH_UA && b <= CH_UF) begin
      d = 4'(b - CH_UA + HEX_TEN);
    end else begin
      return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic emit(input logic [7:0] b, input logic fin);
    step_words.push_back('{data: b, last: fin});
  endtask

  task automatic close_string();
    emit(CH_NUL, 1'b1);
    scan_state = MODE_TEXT;
    escape_value = 8'h00;
  endtask

  task automatic plain_char(input logic [7:0] b, output bit ended);
    ended = 1'b0;
    if (b == CH_NUL) begin
      close_string();
      ended = 1'b1;
    end else if (b == CH_BSL) begin
      scan_state = MODE_BSL;
    end else begin
      emit(b, 1'b0);
    end
  endtask

  task automatic decode_char(input logic [7:0] b, input logic fin);
    logic [7:0] code;
    logic [3:0] d;
    bit         ended;
    ended = 1'b0;
    step_words.delete();
    case (scan_state)
      MODE_BSL: begin
        if (simple_code(b, code)) begin
          emit(code, 1'b0);
          scan_state = MODE_TEXT;
        end else if (b == CH_X) begin
          scan_state = MODE_HEX;
          escape_value = 8'h00;
        end else if (b == CH_ZERO) begin
          scan_state = MODE_OCT;
          escape_value = 8'h00;
        end else begin
          emit(CH_BSL, 1'b0);
          scan_state = MODE_TEXT;
          plain_char(b, ended);
        end
      end
      MODE_HEX: begin
        if (hex_digit(b, d)) begin
          escape_value = {escape_value[3:0], d};
        end else begin
          emit(escape_value, 1'b0);
          scan_state = MODE_TEXT;
          plain_char(b, ended);
        end
      end
      MODE_OCT: begin
        if (b >= CH_ZERO && b <= CH_SEVEN) begin
          escape_value = {escape_value[4:0], b[2:0]};
        end else begin
          emit(escape_value, 1'b0);
          scan_state = MODE_TEXT;
          plain_char(b, ended);
        end
      end
      default: begin
        plain_char(b, ended);
      end
    endcase
    if (!ended && fin) begin
      if (scan_state == MODE_BSL) begin
        emit(CH_BSL, 1'b0);
      end else if (scan_state == MODE_HEX || scan_state == MODE_OCT) begin
        emit(escape_value, 1'b0);
      end
      close_string();
    end
  endtask

  task automatic send_char(input char_t c, input bit may_idle, input bit keep_prediction);
    int gap;
    if (may_idle && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= c.ch;
    in_last <= c.lst;
    do @(posedge clk); while (!in_ready);
    decode_char(c.ch, c.lst);
    if (keep_prediction) begin
      foreach (step_words[k]) expected_words.push_back(step_words[k]);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_words.size() != 0);
  endtask

  task automatic put_char(input logic [7:0] b);
    random_chars.push_back('{ch: b, lst: 1'b0});
  endtask

  task automatic add_string();
    int         tokens;
    int         digits;
    int         pick;
    logic [7:0] b;
    tokens = $urandom_range(1, 8);
    for (int j = 0; j < tokens; j++) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          b = 8'($urandom_range(32, 126));
          put_char(b == CH_BSL ? 8'h5F : b);
        end
        2: begin
          put_char(CH_BSL);
          put_char(ESC_CHARS[$urandom_range(0, 9)]);
        end
        3, 4: begin
          put_char(CH_BSL);
          put_char(CH_X);
          digits = $urandom_range(0, 4);
          repeat (digits) begin
            pick = $urandom_range(0, 21);
            if (pick < 10) begin
              put_char(8'(CH_ZERO + pick));
            end else if (pick < 16) begin
              put_char(8'(CH_LA + pick - 10));
            end else begin
              put_char(8'(CH_UA + pick - 16));
            end
          end
        end
        5, 6: begin
          put_char(CH_BSL);
          put_char(CH_ZERO);
          digits = $urandom_range(0, 4);
          repeat (digits) put_char(8'(CH_ZERO + $urandom_range(0, 7)));
        end
        7: begin
          put_char(CH_BSL);
          put_char(8'($urandom_range(1, 255)));
        end
        default: begin
          put_char(8'($urandom_range(0, 255)));
        end
      endcase
    end
    case ($urandom_range(0, 3))
      0, 1: random_chars[random_chars.size() - 1].lst = 1'b1;
      2: random_chars.push_back('{ch: CH_NUL, lst: 1'($urandom_range(0, 1))});
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        $error("unexpected word: out_byte %h out_string_end %b", out_byte, out_string_end);
        errors++;
      end else begin
        oldest_word = expected_words.pop_front();
        if (out_byte !== oldest_word.data) begin
          $error("out_byte expected %h actual %h", oldest_word.data, out_byte);
          errors++;
        end
        if (out_string_end !== oldest_word.last) begin
          $error("out_string_end expected %b actual %b", oldest_word.last, out_string_end);
          errors++;
        end
      end
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (!calm_tail && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 8);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin
    char_t c;
    int    tail_start;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < DIR_ROWS; i++) begin
      c = '{ch: DIR_TABLE[i].ch, lst: DIR_TABLE[i].lst};
      send_char(c, 1'b1, !DIR_TABLE[i].typed);
      if (DIR_TABLE[i].typed) begin
        if (DIR_TABLE[i].n > 0) expected_words.push_back(DIR_TABLE[i].w0);
        if (DIR_TABLE[i].n > 1) expected_words.push_back(DIR_TABLE[i].w1);
      end
    end
    wait_drained();
    while (random_chars.size() < RAND_CHARS) add_string();
    tail_start = random_chars.size() - CALM_CHARS;
    for (int i = 0; i < random_chars.size(); i++) begin
      if (i == random_chars.size() / 2) wait_drained();
      if (i == tail_start) calm_tail <= 1'b1;
      send_char(random_chars[i], i < tail_start, 1'b1);
    end
    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("PASS c_escape_sequence_decoder");
    end else begin
      $display("FAIL c_escape_sequence_decoder");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL c_escape_sequence_decoder");
    $finish;
  end

endmodule
